// File: rtl/pcbe_pkg.sv
package pcbe_pkg;

    localparam int SEGMENTS  = 16;
    localparam int SEG_W     = $clog2(SEGMENTS);
    localparam int CP_DEPTH  = SEGMENTS * 12;
    localparam int CP_AW     = $clog2(CP_DEPTH);
    localparam int BP_AW     = (SEG_W > 0) ? SEG_W : 1;
    localparam int CNT_W     = 5;

    typedef enum logic [1:0] {
        CMD_WRITE_POINT = 2'd0,
        CMD_WRITE_BREAK = 2'd1,
        CMD_EVALUATE    = 2'd2,
        CMD_UNUSED      = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PREV,
        ST_DIV,
        ST_WEIGHT,
        ST_FETCH,
        ST_MAC,
        ST_ROUND,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic search_start;
        logic search_step;
        logic prev_load;
        logic div_start;
        logic div_step;
        logic weight_step;
        logic fetch;
        logic mac;
        logic round_coord;
        logic clear_out;
    } t_ctrl;

    typedef struct packed {
        logic search_done;
        logic div_done;
        logic weight_done;
        logic mac_last;
        logic coord_last;
    } t_stat;

endpackage

// File: rtl/pcbe_if.sv
interface pcbe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [4:0]  segment;
    logic [1:0]  point;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic [16:0] breakpoint;
    logic signed [17:0] position;
    modport source (output valid, command, segment, point, x_in, y_in, z_in,
                    breakpoint, position, input ready);
    modport sink (input valid, command, segment, point, x_in, y_in, z_in,
                  breakpoint, position, output ready);
endinterface

interface pcbe_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic [3:0]  found_segment;
    logic        status;
    modport source (output valid, x_out, y_out, z_out, found_segment, status,
                    input ready);
    modport sink (input valid, x_out, y_out, z_out, found_segment, status,
                  output ready);
endinterface

interface pcbe_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: rtl/pcbe_ram.sv
module pcbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/pcbe_ctrl.sv
module pcbe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start_eval,
    input  logic            i_start_write,
    input  logic            i_out_taken,
    input  pcbe_pkg::t_stat i_stat,
    output pcbe_pkg::t_ctrl o_ctrl,
    output logic            o_idle,
    output logic            o_out_valid
);
    pcbe_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcbe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcbe_pkg::ST_IDLE: begin
                if (i_start_eval) n_state = pcbe_pkg::ST_SEARCH;
                else if (i_start_write) n_state = pcbe_pkg::ST_DONE;
            end
            pcbe_pkg::ST_SEARCH: begin
                if (i_stat.search_done) n_state = pcbe_pkg::ST_PREV;
            end
            pcbe_pkg::ST_PREV:   n_state = pcbe_pkg::ST_DIV;
            pcbe_pkg::ST_DIV: begin
                if (i_stat.div_done) n_state = pcbe_pkg::ST_WEIGHT;
            end
            pcbe_pkg::ST_WEIGHT: begin
                if (i_stat.weight_done) n_state = pcbe_pkg::ST_FETCH;
            end
            pcbe_pkg::ST_FETCH:  n_state = pcbe_pkg::ST_MAC;
            pcbe_pkg::ST_MAC: begin
                if (i_stat.mac_last) n_state = pcbe_pkg::ST_ROUND;
                else n_state = pcbe_pkg::ST_FETCH;
            end
            pcbe_pkg::ST_ROUND: begin
                if (i_stat.coord_last) n_state = pcbe_pkg::ST_DONE;
                else n_state = pcbe_pkg::ST_FETCH;
            end
            pcbe_pkg::ST_DONE: begin
                if (i_out_taken) n_state = pcbe_pkg::ST_IDLE;
            end
            default: n_state = pcbe_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_ctrl = '0;
        o_idle = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            pcbe_pkg::ST_IDLE: begin
                o_idle = 1'b1;
                o_ctrl.search_start = i_start_eval;
                o_ctrl.clear_out = i_start_write;
            end
            pcbe_pkg::ST_SEARCH: o_ctrl.search_step = 1'b1;
            pcbe_pkg::ST_PREV: begin
                o_ctrl.prev_load = 1'b1;
                o_ctrl.div_start = 1'b1;
            end
            pcbe_pkg::ST_DIV:    o_ctrl.div_step = 1'b1;
            pcbe_pkg::ST_WEIGHT: o_ctrl.weight_step = 1'b1;
            pcbe_pkg::ST_FETCH:  o_ctrl.fetch = 1'b1;
            pcbe_pkg::ST_MAC:    o_ctrl.mac = 1'b1;
            pcbe_pkg::ST_ROUND:  o_ctrl.round_coord = 1'b1;
            pcbe_pkg::ST_DONE:   o_out_valid = 1'b1;
            default: o_idle = 1'b0;
        endcase
    end

    // The result is only offered once the sequencer has finished.
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == pcbe_pkg::ST_DONE)
        else $error("valid outside done");
    // A pending result is held until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_taken) |=> o_out_valid)
        else $error("result dropped");
    // A finished division always leads to weight computation.
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcbe_pkg::ST_DIV && i_stat.div_done) |=>
        r_state == pcbe_pkg::ST_WEIGHT)
        else $error("division exit");
endmodule

// File: rtl/pcbe_dp.sv
module pcbe_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcbe_pkg::t_ctrl    i_ctrl,
    output pcbe_pkg::t_stat    o_stat,
    input  logic               i_accept,
    input  logic [1:0]         i_command,
    input  logic [4:0]         i_segment,
    input  logic [1:0]         i_point,
    input  logic [31:0]        i_x,
    input  logic [31:0]        i_y,
    input  logic [31:0]        i_z,
    input  logic [16:0]        i_breakpoint,
    input  logic [17:0]        i_position,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data,
    output logic [31:0]        o_x,
    output logic [31:0]        o_y,
    output logic [31:0]        o_z,
    output logic [3:0]         o_found,
    output logic               o_status
);
    localparam int SW = pcbe_pkg::BP_AW;

    // Segment count register, clamped for use.
    logic [4:0] r_count;
    logic [5:0] count_eff;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 5'd1;
        else if (i_cfg_we) r_count <= i_cfg_data;
    end
    always_comb begin
        if (r_count == 5'd0) count_eff = 6'd1;
        else if ({1'b0, r_count} > 6'(pcbe_pkg::SEGMENTS)) count_eff = 6'(pcbe_pkg::SEGMENTS);
        else count_eff = {1'b0, r_count};
    end

    logic wr_ok;
    assign wr_ok = {1'b0, i_segment} < count_eff;

    // Clamped query position.
    logic [16:0] pos_clamp;
    always_comb begin
        if (i_position[17]) pos_clamp = '0;
        else if (i_position[16:0] > 17'd65536) pos_clamp = 17'd65536;
        else pos_clamp = i_position[16:0];
    end

    logic [16:0] r_pos;
    logic [SW-1:0] r_idx;
    logic r_search_wait;

    // Breakpoint store.
    logic bp_we;
    logic [SW-1:0] bp_raddr;
    logic [16:0] bp_rdata;
    assign bp_we = i_accept && i_command == pcbe_pkg::CMD_WRITE_BREAK && wr_ok;
    pcbe_ram #(.WIDTH(17), .DEPTH(pcbe_pkg::SEGMENTS)) u_bp (
        .i_clk(i_clk), .i_we(bp_we), .i_waddr(i_segment[SW-1:0]),
        .i_wdata(i_breakpoint), .i_raddr(bp_raddr), .o_rdata(bp_rdata));

    // Control point stores, one per coordinate.
    logic cp_we;
    logic [pcbe_pkg::CP_AW-1:0] cp_waddr, cp_raddr;
    logic [31:0] cpx, cpy, cpz;
    logic [1:0] r_k, r_c;
    assign cp_we = i_accept && i_command == pcbe_pkg::CMD_WRITE_POINT && wr_ok;
    assign cp_waddr = pcbe_pkg::CP_AW'({i_segment[SW-1:0], i_point});
    assign cp_raddr = pcbe_pkg::CP_AW'({r_idx, r_k});
    pcbe_ram #(.WIDTH(32), .DEPTH(pcbe_pkg::SEGMENTS * 4)) u_cpx (
        .i_clk(i_clk), .i_we(cp_we), .i_waddr(cp_waddr[SW+1:0]), .i_wdata(i_x),
        .i_raddr(cp_raddr[SW+1:0]), .o_rdata(cpx));
    pcbe_ram #(.WIDTH(32), .DEPTH(pcbe_pkg::SEGMENTS * 4)) u_cpy (
        .i_clk(i_clk), .i_we(cp_we), .i_waddr(cp_waddr[SW+1:0]), .i_wdata(i_y),
        .i_raddr(cp_raddr[SW+1:0]), .o_rdata(cpy));
    pcbe_ram #(.WIDTH(32), .DEPTH(pcbe_pkg::SEGMENTS * 4)) u_cpz (
        .i_clk(i_clk), .i_we(cp_we), .i_waddr(cp_waddr[SW+1:0]), .i_wdata(i_z),
        .i_raddr(cp_raddr[SW+1:0]), .o_rdata(cpz));

    // Linear breakpoint search: each entry takes an address phase, then a data phase.
    logic [SW:0] idx_last;
    assign idx_last = (SW+1)'(count_eff - 6'd1);
    logic r_prev_phase;
    logic [16:0] r_bp;
    always_comb begin
        bp_raddr = r_idx;
        if (i_ctrl.prev_load || r_prev_phase) bp_raddr = r_idx - SW'(1);
    end
    logic at_last;
    assign at_last = {1'b0, r_idx} == idx_last;
    assign o_stat.search_done = i_ctrl.search_step && !r_search_wait &&
                                (at_last || !(r_pos > bp_rdata));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_wait <= 1'b0;
            r_prev_phase <= 1'b0;
        end else begin
            if (i_ctrl.search_start) r_search_wait <= 1'b1;
            else if (i_ctrl.search_step) r_search_wait <= !r_search_wait && !o_stat.search_done;
            r_prev_phase <= 1'b0;
        end
        if (i_ctrl.search_start) begin
            r_pos <= pos_clamp;
            r_idx <= '0;
        end else if (i_ctrl.search_step && !r_search_wait) begin
            if (o_stat.search_done) r_bp <= bp_rdata;
            else r_idx <= r_idx + SW'(1);
        end
    end

    // Division unit: restoring, one quotient bit per cycle, 16 bits.
    logic [17:0] r_rem;
    logic [17:0] r_den;
    logic [16:0] r_q;
    logic [4:0] r_dcnt;
    logic r_t_zero, r_t_one;
    logic [16:0] r_t;
    logic r_div_wait;
    logic [17:0] num_w, den_w, prev_v;
    logic [18:0] trial;
    assign trial = {r_rem, 1'b0} - {1'b0, r_den};
    assign o_stat.div_done = i_ctrl.div_step && !r_div_wait && r_dcnt == 5'd0;
    always_comb begin
        prev_v = (r_idx == '0) ? 18'd0 : {1'b0, bp_rdata};
        num_w = {1'b0, r_pos} - prev_v;
        den_w = {1'b0, r_bp} - prev_v;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_div_wait <= 1'b0;
        else if (i_ctrl.div_start) r_div_wait <= 1'b1;
        else if (i_ctrl.div_step) r_div_wait <= 1'b0;
        if (i_ctrl.div_start) begin
            r_dcnt <= 5'd16;
        end else if (i_ctrl.div_step && r_div_wait) begin
            // Breakpoint data for the previous segment is now present.
            r_den <= den_w;
            r_rem <= num_w;
            r_q <= '0;
            r_t_zero <= den_w[17] || den_w == 18'd0 || num_w[17] || num_w == 18'd0;
            r_t_one <= !(num_w < den_w);
        end else if (i_ctrl.div_step && r_dcnt != 5'd0) begin
            r_dcnt <= r_dcnt - 5'd1;
            if (!trial[18]) begin
                r_rem <= trial[17:0];
                r_q <= {r_q[15:0], 1'b1};
            end else begin
                r_rem <= {r_rem[16:0], 1'b0};
                r_q <= {r_q[15:0], 1'b0};
            end
        end
        if (o_stat.div_done) begin
            if (r_t_zero) r_t <= '0;
            else if (r_t_one) r_t <= 17'd65536;
            else r_t <= r_q;
        end
    end

    // Bernstein weights: a shared 17x34 multiply, stepped through the products in turn.
    logic [2:0] r_wstep;
    logic [33:0] r_sq_t, r_sq_u, r_tu;
    logic [50:0] r_mul_out;
    logic [29:0] r_w [4];
    logic [16:0] u_v;
    assign u_v = 17'd65536 - r_t;
    logic [16:0] ma;
    logic [33:0] mb;
    logic [50:0] prod;
    always_comb begin
        ma = r_t;
        mb = {17'd0, r_t};
        case (r_wstep)
            3'd0: begin ma = r_t; mb = {17'd0, r_t}; end
            3'd1: begin ma = u_v; mb = {17'd0, u_v}; end
            3'd2: begin ma = r_t; mb = {17'd0, u_v}; end
            3'd3: begin ma = r_t; mb = r_sq_t; end
            3'd4: begin ma = u_v; mb = r_sq_u; end
            3'd5: begin ma = u_v; mb = r_tu; end
            3'd6: begin ma = r_t; mb = r_tu; end
            default: begin ma = r_t; mb = r_sq_t; end
        endcase
        prod = 51'(ma) * 51'(mb);
    end
    assign o_stat.weight_done = i_ctrl.weight_step && r_wstep == 3'd7;
    logic [51:0] w3x;
    assign w3x = {r_mul_out, 1'b0} + {1'b0, r_mul_out} + 52'(1 << 17);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wstep <= '0;
        else if (i_ctrl.weight_step) r_wstep <= r_wstep + 3'd1;
        if (i_ctrl.weight_step) begin
            r_mul_out <= prod;
            case (r_wstep)
                3'd1: r_sq_t <= r_mul_out[33:0];
                3'd2: r_sq_u <= r_mul_out[33:0];
                3'd3: r_tu <= r_mul_out[33:0];
                3'd4: r_w[3] <= 30'((r_mul_out + 51'(1 << 17)) >> 18);
                3'd5: r_w[0] <= 30'((r_mul_out + 51'(1 << 17)) >> 18);
                3'd6: r_w[1] <= 30'(w3x >> 18);
                default: begin
                    if (r_wstep == 3'd7) r_w[2] <= 30'(w3x >> 18);
                end
            endcase
        end
    end

    // Blend: one 32x31 product per point, accumulated per coordinate.
    logic [31:0] cp_sel;
    always_comb begin
        case (r_c)
            2'd0: cp_sel = cpx;
            2'd1: cp_sel = cpy;
            default: cp_sel = cpz;
        endcase
    end
    logic signed [62:0] r_prod;
    logic signed [65:0] r_acc;
    logic [31:0] r_cp0, r_cp3;
    logic r_mac_wait;
    assign o_stat.mac_last = i_ctrl.mac && r_k == 2'd3 && !r_mac_wait;
    assign o_stat.coord_last = r_c == 2'd2;
    logic signed [65:0] acc_sum, biased;
    logic signed [36:0] rnd;
    logic [31:0] sat;
    always_comb begin
        acc_sum = r_acc + 66'(r_prod);
        biased = acc_sum + 66'sd536870912;
        rnd = 37'(biased >>> 30);
        if (rnd > 37'sd2147483647) sat = 32'h7fffffff;
        else if (rnd < -37'sd2147483648) sat = 32'h80000000;
        else sat = rnd[31:0];
    end
    logic [31:0] coord;
    always_comb begin
        if (r_t == '0) coord = r_cp0;
        else if (r_t == 17'd65536) coord = r_cp3;
        else coord = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_c <= '0;
            r_mac_wait <= 1'b0;
        end else begin
            if (i_ctrl.search_start) begin
                r_k <= '0;
                r_c <= '0;
            end
            if (i_ctrl.fetch) r_mac_wait <= 1'b0;
            if (i_ctrl.mac) begin
                if (r_k != 2'd3) r_k <= r_k + 2'd1;
                else r_mac_wait <= 1'b1;
            end
            if (i_ctrl.round_coord) begin
                r_k <= '0;
                r_c <= r_c + 2'd1;
            end
        end
        if (i_ctrl.mac) begin
            r_prod <= $signed(cp_sel) * $signed({1'b0, r_w[r_k]});
            if (r_k == 2'd0) begin
                r_acc <= '0;
                r_cp0 <= cp_sel;
            end else begin
                r_acc <= r_acc + 66'(r_prod);
            end
            if (r_k == 2'd3) r_cp3 <= cp_sel;
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear_out || (i_accept && i_command == pcbe_pkg::CMD_UNUSED)) begin
            o_x <= '0;
            o_y <= '0;
            o_z <= '0;
            o_found <= '0;
            o_status <= i_command != pcbe_pkg::CMD_UNUSED && !wr_ok;
        end
        if (i_ctrl.search_start) o_status <= 1'b0;
        if (o_stat.search_done) o_found <= 4'(r_idx);
        if (i_ctrl.round_coord) begin
            case (r_c)
                2'd0: o_x <= coord;
                2'd1: o_y <= coord;
                default: o_z <= coord;
            endcase
        end
    end

    // Search never runs beyond the last segment in use.
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.search_step |-> {1'b0, r_idx} <= idx_last)
        else $error("search index past count");
    // The blend only ever works on the three coordinates.
    a_wk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.mac |-> r_c != 2'd3)
        else $error("bad coordinate");
    // The quotient is in range once division ends.
    a_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.div_done |=> r_t <= 17'd65536)
        else $error("t out of range");
endmodule

// File: rtl/piecewise_cubic_bezier_eval.sv
// Channel   Dir   Handshake      Payload
// in        in    valid/ready    command segment point x_in y_in z_in breakpoint position
// out       out   valid/ready    x_out y_out z_out found_segment status
// cfg       in    valid/ready    segment_count
//
// Writes and the unused command go from acceptance straight to the result.
// An evaluation searches the breakpoints linearly, then runs the bit-serial divider,
// the weight steps and the shared blend multiplier for each coordinate.
// One item at a time: in.ready is high only while the sequencer is idle.
// Synchronous active-low reset sets segment_count to 1; stores are not cleared.
// A result waits in its register while out.ready is low.
module piecewise_cubic_bezier_eval (
    input  logic i_clk,
    input  logic i_rst_n,
    pcbe_in_if.sink    in_ch,
    pcbe_out_if.source out_ch,
    pcbe_cfg_if.sink   cfg_ch
);
    pcbe_pkg::t_ctrl ctrl;
    pcbe_pkg::t_stat stat;
    logic idle, accept;

    assign in_ch.ready = idle;
    assign cfg_ch.ready = 1'b1;
    assign accept = in_ch.valid && idle;

    pcbe_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start_eval(accept && in_ch.command == pcbe_pkg::CMD_EVALUATE),
        .i_start_write(accept && in_ch.command != pcbe_pkg::CMD_EVALUATE),
        .i_out_taken(out_ch.ready), .i_stat(stat), .o_ctrl(ctrl),
        .o_idle(idle), .o_out_valid(out_ch.valid));

    pcbe_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .o_stat(stat),
        .i_accept(accept), .i_command(in_ch.command), .i_segment(in_ch.segment),
        .i_point(in_ch.point), .i_x(in_ch.x_in), .i_y(in_ch.y_in), .i_z(in_ch.z_in),
        .i_breakpoint(in_ch.breakpoint), .i_position(in_ch.position),
        .i_cfg_we(cfg_ch.valid), .i_cfg_data(cfg_ch.data),
        .o_x(out_ch.x_out), .o_y(out_ch.y_out), .o_z(out_ch.z_out),
        .o_found(out_ch.found_segment), .o_status(out_ch.status));
endmodule
